// ----- design/tbts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbts_pkg
// shared types and constants for the triangle bbox / tile binning setup block
// ----------------------------------------------------------------------------
package tbts_pkg;

    localparam int SUBPIXEL_BITS_DEF      = 3;
    localparam int TILE_SIZE_LOG2_DEF     = 4;
    localparam int MAX_BATCH_PRIMS_DEF    = 16384;
    localparam int MAX_TILE_INSTANCES_DEF = 65535;

    localparam int SCISSOR_LIMIT = 2048;
    localparam int QUEUE_DEPTH   = 4;

    localparam int XW       = 32;
    localparam int YW       = 16;
    localparam int COORD_W  = 12;
    localparam int TILE_W   = 17;
    localparam int SLOT_W   = 14;

    localparam logic [TILE_W-1:0] COUNT_MAX = {TILE_W{1'b1}};

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCISSOR_X      = 2'd0,
        CFG_SCISSOR_Y      = 2'd1,
        CFG_SCISSOR_WIDTH  = 2'd2,
        CFG_SCISSOR_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [11:0] width;
        logic [11:0] height;
    } scissor_t;

    typedef struct packed {
        logic                    vis;
        logic [COORD_W-1:0]      min_x;
        logic [COORD_W-1:0]      max_x;
        logic [COORD_W-1:0]      min_y;
        logic [COORD_W-1:0]      max_y;
        logic [TILE_W-1:0]       tiles;
    } box_t;

endpackage
`default_nettype wire

// ----- design/tbts_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbts interfaces
// valid/ready channels for triangle setup words and binning result words
// ----------------------------------------------------------------------------
interface tbts_prim_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] edge_a_x;
    logic signed [31:0] edge_b_x;
    logic signed [31:0] edge_c_x;
    logic signed [31:0] slope_a;
    logic signed [31:0] slope_b;
    logic signed [31:0] slope_c;
    logic signed [15:0] top_y;
    logic signed [15:0] middle_y;
    logic signed [15:0] bottom_y;

    modport source (
        output valid, edge_a_x, edge_b_x, edge_c_x, slope_a, slope_b, slope_c,
               top_y, middle_y, bottom_y,
        input  ready
    );
    modport sink (
        input  valid, edge_a_x, edge_b_x, edge_c_x, slope_a, slope_b, slope_c,
               top_y, middle_y, bottom_y,
        output ready
    );
endinterface

interface tbts_result_if;
    logic               valid;
    logic               ready;
    logic               visible;
    logic signed [12:0] box_min_x;
    logic signed [12:0] box_max_x;
    logic signed [12:0] box_min_y;
    logic signed [12:0] box_max_y;
    logic [16:0]        num_tiles;
    logic               batch_closed;
    logic [13:0]        batch_slot;

    modport source (
        output valid, visible, box_min_x, box_max_x, box_min_y, box_max_y,
               num_tiles, batch_closed, batch_slot,
        input  ready
    );
    modport sink (
        input  valid, visible, box_min_x, box_max_x, box_min_y, box_max_y,
               num_tiles, batch_closed, batch_slot,
        output ready
    );
endinterface
`default_nettype wire

// ----- design/tbts_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbts_front
// setup pipeline: edge end points, x/y extent, scissor clip and tile count
// ----------------------------------------------------------------------------
module tbts_front #(
    parameter int SUBPIXEL_BITS  = tbts_pkg::SUBPIXEL_BITS_DEF,
    parameter int TILE_SIZE_LOG2 = tbts_pkg::TILE_SIZE_LOG2_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tbts_prim_if.sink              prim,
    input  wire tbts_pkg::scissor_t scissor,
    input  wire logic              q_full,
    output logic                   box_valid,
    output tbts_pkg::box_t         box
);
    import tbts_pkg::*;

    localparam int XS  = 16 + SUBPIXEL_BITS;
    localparam int CW  = 18;
    localparam int TWW = COORD_W + 1;
    localparam logic signed [XW:0]  ROUND_X = (XW+1)'((64'd1 << XS) - 64'd1);
    localparam logic signed [YW:0]  ROUND_Y = (YW+1)'((64'd1 << SUBPIXEL_BITS) - 64'd1);
    localparam logic [11:0] SC_LIMIT = 12'(SCISSOR_LIMIT);

    function automatic logic signed [XW-1:0] smin(input logic signed [XW-1:0] a,
                                                  input logic signed [XW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [XW-1:0] smax(input logic signed [XW-1:0] a,
                                                  input logic signed [XW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [CW-1:0] cmin(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [CW-1:0] cmax(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic       advance;
    logic [4:0] v_reg;

    // stage 1: spans and products
    logic [YW:0]     span_a, span_b, span_c;
    logic [XW-1:0]   pa_next, pb_next, pc_next;
    logic [XW-1:0]   pa_reg, pb_reg, pc_reg;
    logic [XW-1:0]   xa1_reg, xb1_reg, xc1_reg;
    logic signed [YW-1:0] ylo1_reg, yhi1_reg;

    // stage 2: end points
    logic signed [XW-1:0] xa2_reg, xb2_reg, xc2_reg, ea2_reg, eb2_reg, ec2_reg;
    logic signed [YW-1:0] ylo2_reg, yhi2_reg;

    // stage 3: extent
    logic signed [XW-1:0] lo_next, hi_next, lo3_reg, hi3_reg;
    logic signed [YW-1:0] ylo3_reg, yhi3_reg;

    // stage 4: rounding and clip
    logic signed [XW:0]   bx0_sum, bx1_sum, bx0_sh, bx1_sh;
    logic signed [YW:0]   by0_sum, by1_sum, by0_sh, by1_sh;
    logic signed [CW-1:0] bx0, bx1, by0, by1;
    logic [11:0]          sw, sh;
    logic signed [13:0]   xlim, ylim;
    logic signed [CW-1:0] cx0, cx1, cy0, cy1;
    logic                 vis_next, vis4_reg;
    logic [COORD_W-1:0]   cx0_reg, cx1_reg, cy0_reg, cy1_reg;

    // stage 5: tile count
    logic [TWW-1:0]       tw, th;
    logic [2*TWW-1:0]     tprod;
    logic [TILE_W-1:0]    tiles;
    box_t                 box_next, box_reg;

    assign advance    = !v_reg[4] || !q_full;
    assign prim.ready = advance;
    assign box_valid  = v_reg[4];
    assign box        = box_reg;

    always_comb
    begin
        span_a  = {prim.bottom_y[YW-1], prim.bottom_y} - {prim.top_y[YW-1], prim.top_y};
        span_b  = {prim.middle_y[YW-1], prim.middle_y} - {prim.top_y[YW-1], prim.top_y};
        span_c  = {prim.bottom_y[YW-1], prim.bottom_y}
                - {prim.middle_y[YW-1], prim.middle_y};
        pa_next = XW'($unsigned(prim.slope_a) * {{(XW-YW-1){span_a[YW]}}, span_a});
        pb_next = XW'($unsigned(prim.slope_b) * {{(XW-YW-1){span_b[YW]}}, span_b});
        pc_next = XW'($unsigned(prim.slope_c) * {{(XW-YW-1){span_c[YW]}}, span_c});
    end

    always_comb
    begin
        lo_next = smin(smin(smin(xa2_reg, xb2_reg), smin(xc2_reg, ea2_reg)),
                       smin(eb2_reg, ec2_reg));
        hi_next = smax(smax(smax(xa2_reg, xb2_reg), smax(xc2_reg, ea2_reg)),
                       smax(eb2_reg, ec2_reg));
    end

    always_comb
    begin
        bx0_sum = $signed({lo3_reg[XW-1], lo3_reg}) + ROUND_X;
        bx1_sum = $signed({hi3_reg[XW-1], hi3_reg}) - (XW+1)'(1);
        bx0_sh  = bx0_sum >>> XS;
        bx1_sh  = bx1_sum >>> XS;
        bx0     = bx0_sh[CW-1:0];
        bx1     = bx1_sh[CW-1:0];
        by0_sum = $signed({ylo3_reg[YW-1], ylo3_reg}) + ROUND_Y;
        by1_sum = $signed({yhi3_reg[YW-1], yhi3_reg}) - (YW+1)'(1);
        by0_sh  = by0_sum >>> SUBPIXEL_BITS;
        by1_sh  = by1_sum >>> SUBPIXEL_BITS;
        by0     = {by0_sh[YW], by0_sh};
        by1     = {by1_sh[YW], by1_sh};
        sw      = (scissor.width > SC_LIMIT) ? SC_LIMIT : scissor.width;
        sh      = (scissor.height > SC_LIMIT) ? SC_LIMIT : scissor.height;
        xlim    = $signed({3'b0, scissor.x}) + $signed({2'b0, sw}) - 14'sd1;
        ylim    = $signed({3'b0, scissor.y}) + $signed({2'b0, sh}) - 14'sd1;
        cx0     = cmax($signed({7'b0, scissor.x}), bx0);
        cx1     = cmin({{(CW-14){xlim[13]}}, xlim}, bx1);
        cy0     = cmax($signed({7'b0, scissor.y}), by0);
        cy1     = cmin({{(CW-14){ylim[13]}}, ylim}, by1);
        vis_next = (cx0 <= cx1) && (cy0 <= cy1);
    end

    always_comb
    begin
        tw    = TWW'(cx1_reg >> TILE_SIZE_LOG2) - TWW'(cx0_reg >> TILE_SIZE_LOG2) + TWW'(1);
        th    = TWW'(cy1_reg >> TILE_SIZE_LOG2) - TWW'(cy0_reg >> TILE_SIZE_LOG2) + TWW'(1);
        tprod = tw * th;
        if (!vis4_reg)
            tiles = '0;
        else if (tprod > (2*TWW)'(COUNT_MAX))
            tiles = COUNT_MAX;
        else
            tiles = tprod[TILE_W-1:0];
        box_next.vis   = vis4_reg;
        box_next.min_x = cx0_reg;
        box_next.max_x = cx1_reg;
        box_next.min_y = cy0_reg;
        box_next.max_y = cy1_reg;
        box_next.tiles = tiles;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[3:0], prim.valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pc_reg   <= pc_next;
            xa1_reg  <= prim.edge_a_x;
            xb1_reg  <= prim.edge_b_x;
            xc1_reg  <= prim.edge_c_x;
            ylo1_reg <= prim.top_y;
            yhi1_reg <= prim.bottom_y;

            xa2_reg  <= xa1_reg;
            xb2_reg  <= xb1_reg;
            xc2_reg  <= xc1_reg;
            ea2_reg  <= xa1_reg + pa_reg;
            eb2_reg  <= xb1_reg + pb_reg;
            ec2_reg  <= xc1_reg + pc_reg;
            ylo2_reg <= ylo1_reg;
            yhi2_reg <= yhi1_reg;

            lo3_reg  <= lo_next;
            hi3_reg  <= hi_next;
            ylo3_reg <= ylo2_reg;
            yhi3_reg <= yhi2_reg;

            vis4_reg <= vis_next;
            cx0_reg  <= vis_next ? cx0[COORD_W-1:0] : '0;
            cx1_reg  <= vis_next ? cx1[COORD_W-1:0] : '0;
            cy0_reg  <= vis_next ? cy0[COORD_W-1:0] : '0;
            cy1_reg  <= vis_next ? cy1[COORD_W-1:0] : '0;

            box_reg  <= box_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/tbts_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbts_queue
// small fifo of clipped boxes between the setup pipeline and batch accounting
// ----------------------------------------------------------------------------
module tbts_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tbts_pkg::box_t push_data,
    output logic               full,
    input  wire logic          pop,
    output tbts_pkg::box_t     pop_data,
    output logic               empty
);
    import tbts_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    box_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ----- design/tbts_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbts_back
// batch accounting and result output register
// ----------------------------------------------------------------------------
module tbts_back #(
    parameter int MAX_BATCH_PRIMS    = tbts_pkg::MAX_BATCH_PRIMS_DEF,
    parameter int MAX_TILE_INSTANCES = tbts_pkg::MAX_TILE_INSTANCES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire tbts_pkg::box_t q_data,
    output logic                q_pop,
    tbts_result_if.source       result
);
    import tbts_pkg::*;

    localparam int CNT_W = $clog2(MAX_BATCH_PRIMS + 1);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_BATCH_PRIMS);
    localparam logic [TILE_W:0]   TILE_LIM = (TILE_W+1)'(MAX_TILE_INSTANCES);

    logic [CNT_W-1:0]  count_reg, count_next, count_base;
    logic [TILE_W-1:0] total_reg, total_next, total_base;
    logic [TILE_W:0]   trial_sum, new_sum;
    logic              closed;
    logic              valid_reg;
    logic              vis_reg, closed_reg;
    logic [COORD_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [TILE_W-1:0] tiles_reg;
    logic [SLOT_W-1:0] slot_reg;

    assign q_pop = !q_empty && (!valid_reg || result.ready);

    always_comb
    begin
        trial_sum  = {1'b0, total_reg} + {1'b0, q_data.tiles};
        closed     = (count_reg != '0) && ((count_reg >= MAX_CNT) || (trial_sum > TILE_LIM));
        count_base = closed ? '0 : count_reg;
        total_base = closed ? '0 : total_reg;
        count_next = count_base + CNT_W'(1);
        new_sum    = {1'b0, total_base} + {1'b0, q_data.tiles};
        total_next = new_sum[TILE_W] ? COUNT_MAX : new_sum[TILE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                count_reg <= count_next;
                total_reg <= total_next;
                valid_reg <= 1'b1;
            end
            else if (result.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            vis_reg    <= q_data.vis;
            min_x_reg  <= q_data.min_x;
            max_x_reg  <= q_data.max_x;
            min_y_reg  <= q_data.min_y;
            max_y_reg  <= q_data.max_y;
            tiles_reg  <= q_data.tiles;
            closed_reg <= closed;
            slot_reg   <= SLOT_W'(count_base);
        end
    end

    assign result.valid        = valid_reg;
    assign result.visible      = vis_reg;
    assign result.box_min_x    = $signed({1'b0, min_x_reg});
    assign result.box_max_x    = $signed({1'b0, max_x_reg});
    assign result.box_min_y    = $signed({1'b0, min_y_reg});
    assign result.box_max_y    = $signed({1'b0, max_y_reg});
    assign result.num_tiles    = tiles_reg;
    assign result.batch_closed = closed_reg;
    assign result.batch_slot   = slot_reg;

`ifndef SYNTH
    a_closed_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.batch_closed |-> result.batch_slot == '0)
        else $error("closed batch did not restart at slot zero");

    a_invisible_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.visible |-> result.num_tiles == '0
            && result.box_min_x == '0 && result.box_max_x == '0
            && result.box_min_y == '0 && result.box_max_y == '0)
        else $error("invisible box carries nonzero bounds or tiles");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("batch primitive count above maximum");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> valid_reg)
        else $error("popped word not held in output register");
`endif

endmodule
`default_nettype wire

// ----- design/triangle_bbox_tile_binning_setup_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_bbox_tile_binning_setup_top
// triangle bounding box, scissor clip, tile count and batch accounting
// ----------------------------------------------------------------------------
// Takes one triangle setup word per cycle while the queue is not full and
// returns one result word per triangle, in order. A word passes a five-stage
// setup pipeline (end-point multiply, end-point add, extent min/max, rounding
// and scissor clip, tile count), a four-entry queue and the batch accounting
// stage. The sustained rate is one word per cycle when the output is not
// stalled; the batch counters are updated once per word. The user must write
// the scissor registers through the cfg port only while the block is idle;
// the block itself does not enforce this. They take effect on the next word.
module triangle_bbox_tile_binning_setup_top #(
    parameter int SUBPIXEL_BITS      = tbts_pkg::SUBPIXEL_BITS_DEF,
    parameter int TILE_SIZE_LOG2     = tbts_pkg::TILE_SIZE_LOG2_DEF,
    parameter int MAX_BATCH_PRIMS    = tbts_pkg::MAX_BATCH_PRIMS_DEF,
    parameter int MAX_TILE_INSTANCES = tbts_pkg::MAX_TILE_INSTANCES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tbts_prim_if.sink                              prim,
    tbts_result_if.source                          result,
    input  wire logic                              cfg_we,
    input  wire logic [tbts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tbts_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tbts_pkg::*;

    scissor_t scissor_reg;
    box_t     f_box, q_box;
    logic     f_valid, q_full, q_empty, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scissor_reg.x      <= '0;
            scissor_reg.y      <= '0;
            scissor_reg.width  <= 12'(SCISSOR_LIMIT);
            scissor_reg.height <= 12'(SCISSOR_LIMIT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCISSOR_X:      scissor_reg.x      <= cfg_data[10:0];
                CFG_SCISSOR_Y:      scissor_reg.y      <= cfg_data[10:0];
                CFG_SCISSOR_WIDTH:  scissor_reg.width  <= cfg_data;
                CFG_SCISSOR_HEIGHT: scissor_reg.height <= cfg_data;
                default:            scissor_reg        <= scissor_reg;
            endcase
        end
    end

    tbts_front #(
        .SUBPIXEL_BITS  (SUBPIXEL_BITS),
        .TILE_SIZE_LOG2 (TILE_SIZE_LOG2)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .prim      (prim),
        .scissor   (scissor_reg),
        .q_full    (q_full),
        .box_valid (f_valid),
        .box       (f_box)
    );

    tbts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data (f_box),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_box),
        .empty     (q_empty)
    );

    tbts_back #(
        .MAX_BATCH_PRIMS    (MAX_BATCH_PRIMS),
        .MAX_TILE_INSTANCES (MAX_TILE_INSTANCES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_box),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule
`default_nettype wire

// ----- tb/tb_triangle_bbox_tile_binning_setup_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_bbox_tile_binning_setup_top
// self-checking bench for the triangle bbox, scissor clip and tile binning block
// ----------------------------------------------------------------------------
// Triangle setup words go in through a valid/ready channel and every accepted
// word is run through a behavioral binning predictor that keeps its own copy
// of the scissor registers and the batch counters. Each result word is
// compared field by field against the oldest predicted word. Stimulus is a
// short directed set, random phases over several scissor settings and idle
// patterns, a long output hold-off, and a run of empty triangles at the end.
// ----------------------------------------------------------------------------
import tbts_pkg::*;

localparam int     FRAC_BITS  = 16 + SUBPIXEL_BITS_DEF;
localparam longint FRAC_ROUND = (64'sd1 <<< FRAC_BITS) - 1;
localparam longint SUB_ROUND  = (64'sd1 <<< SUBPIXEL_BITS_DEF) - 1;

typedef struct packed {
    logic signed [31:0] edge_a_x;
    logic signed [31:0] edge_b_x;
    logic signed [31:0] edge_c_x;
    logic signed [31:0] slope_a;
    logic signed [31:0] slope_b;
    logic signed [31:0] slope_c;
    logic signed [15:0] top_y;
    logic signed [15:0] middle_y;
    logic signed [15:0] bottom_y;
} triangle_t;

typedef struct packed {
    logic        visible;
    logic [12:0] box_min_x;
    logic [12:0] box_max_x;
    logic [12:0] box_min_y;
    logic [12:0] box_max_y;
    logic [16:0] num_tiles;
    logic        batch_closed;
    logic [13:0] batch_slot;
} bin_word_t;

class bin_scoreboard;
    logic [10:0]  clip_x;
    logic [10:0]  clip_y;
    logic [11:0]  clip_w;
    logic [11:0]  clip_h;
    int unsigned  prim_count;
    longint       batch_tiles;
    bin_word_t    expected_bins[$];
    int unsigned  mismatches;

    function new();
        clip_x      = '0;
        clip_y      = '0;
        clip_w      = 12'(SCISSOR_LIMIT);
        clip_h      = 12'(SCISSOR_LIMIT);
        prim_count  = 0;
        batch_tiles = 0;
        mismatches  = 0;
    endfunction

    function void write_scissor(cfg_reg_t idx, logic [11:0] data);
        case (idx)
            CFG_SCISSOR_X:      clip_x = data[10:0];
            CFG_SCISSOR_Y:      clip_y = data[10:0];
            CFG_SCISSOR_WIDTH:  clip_w = data;
            CFG_SCISSOR_HEIGHT: clip_h = data;
            default: ;
        endcase
    endfunction

    // end point wraps at 32 bits
    function longint edge_end(logic [31:0] start, logic [31:0] slope, longint span);
        logic [31:0]        prod;
        logic signed [31:0] sum;
        prod = slope * span[31:0];
        sum  = start + prod;
        return longint'(sum);
    endfunction

    function bin_word_t predict_binning(triangle_t t);
        longint    ylo, ymid, yhi, lo, hi;
        longint    xs [6];
        longint    bx0, bx1, by0, by1, sw, sh, cx0, cx1, cy0, cy1, tiles;
        bin_word_t w;
        ylo   = longint'($signed(t.top_y));
        ymid  = longint'($signed(t.middle_y));
        yhi   = longint'($signed(t.bottom_y));
        xs[0] = longint'($signed(t.edge_a_x));
        xs[1] = longint'($signed(t.edge_b_x));
        xs[2] = longint'($signed(t.edge_c_x));
        xs[3] = edge_end(t.edge_a_x, t.slope_a, yhi - ylo);
        xs[4] = edge_end(t.edge_b_x, t.slope_b, ymid - ylo);
        xs[5] = edge_end(t.edge_c_x, t.slope_c, yhi - ymid);
        lo = xs[0];
        hi = xs[0];
        foreach (xs[i])
        begin
            if (xs[i] < lo) lo = xs[i];
            if (xs[i] > hi) hi = xs[i];
        end
        bx0 = (lo + FRAC_ROUND) >>> FRAC_BITS;
        bx1 = (hi - 1) >>> FRAC_BITS;
        by0 = (ylo + SUB_ROUND) >>> SUBPIXEL_BITS_DEF;
        by1 = (yhi - 1) >>> SUBPIXEL_BITS_DEF;
        sw  = (clip_w > SCISSOR_LIMIT) ? longint'(SCISSOR_LIMIT) : longint'(clip_w);
        sh  = (clip_h > SCISSOR_LIMIT) ? longint'(SCISSOR_LIMIT) : longint'(clip_h);
        cx0 = (longint'(clip_x) > bx0) ? longint'(clip_x) : bx0;
        cx1 = (longint'(clip_x) + sw - 1 < bx1) ? longint'(clip_x) + sw - 1 : bx1;
        cy0 = (longint'(clip_y) > by0) ? longint'(clip_y) : by0;
        cy1 = (longint'(clip_y) + sh - 1 < by1) ? longint'(clip_y) + sh - 1 : by1;
        w.visible = (cx0 <= cx1) && (cy0 <= cy1);
        if (w.visible)
        begin
            tiles = ((cx1 >>> TILE_SIZE_LOG2_DEF) - (cx0 >>> TILE_SIZE_LOG2_DEF) + 1)
                  * ((cy1 >>> TILE_SIZE_LOG2_DEF) - (cy0 >>> TILE_SIZE_LOG2_DEF) + 1);
            if (tiles > longint'(COUNT_MAX)) tiles = longint'(COUNT_MAX);
        end
        else
        begin
            tiles = 0;
            cx0   = 0;
            cx1   = 0;
            cy0   = 0;
            cy1   = 0;
        end
        // an empty batch never closes
        w.batch_closed = 1'b0;
        if (prim_count != 0 && (prim_count >= MAX_BATCH_PRIMS_DEF ||
                                batch_tiles + tiles > longint'(MAX_TILE_INSTANCES_DEF)))
        begin
            w.batch_closed = 1'b1;
            prim_count     = 0;
            batch_tiles    = 0;
        end
        w.batch_slot = prim_count[13:0];
        prim_count++;
        batch_tiles = batch_tiles + tiles;
        if (batch_tiles > longint'(COUNT_MAX)) batch_tiles = longint'(COUNT_MAX);
        w.box_min_x  = cx0[12:0];
        w.box_max_x  = cx1[12:0];
        w.box_min_y  = cy0[12:0];
        w.box_max_y  = cy1[12:0];
        w.num_tiles  = tiles[16:0];
        return w;
    endfunction

    function void note_triangle(triangle_t t);
        expected_bins.push_back(predict_binning(t));
    endfunction

    function void compare_field(string name, logic [16:0] want, logic [16:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function void check_bin(bin_word_t got);
        bin_word_t want;
        if (expected_bins.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, actual %h", $time, got);
            return;
        end
        want = expected_bins.pop_front();
        compare_field("visible", 17'(want.visible), 17'(got.visible));
        compare_field("box_min_x", 17'(want.box_min_x), 17'(got.box_min_x));
        compare_field("box_max_x", 17'(want.box_max_x), 17'(got.box_max_x));
        compare_field("box_min_y", 17'(want.box_min_y), 17'(got.box_min_y));
        compare_field("box_max_y", 17'(want.box_max_y), 17'(got.box_max_y));
        compare_field("num_tiles", want.num_tiles, got.num_tiles);
        compare_field("batch_closed", 17'(want.batch_closed), 17'(got.batch_closed));
        compare_field("batch_slot", 17'(want.batch_slot), 17'(got.batch_slot));
    endfunction
endclass

module tb_triangle_bbox_tile_binning_setup_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int EMPTY_RUN      = 90;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int            sender_idle_pct;
    int            receiver_stall_pct;
    int unsigned   holdoff_requests;
    int unsigned   quiet_cycles;
    bin_scoreboard scoreboard;
    triangle_t     seen_shape;
    bin_word_t     seen_bin;

    tbts_prim_if   prim_ch ();
    tbts_result_if bin_ch ();

    triangle_bbox_tile_binning_setup_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .prim      (prim_ch),
        .result    (bin_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sample words and register writes at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                scoreboard.write_scissor(cfg_reg_t'(cfg_index), cfg_data);
            if (prim_ch.valid && prim_ch.ready)
            begin
                seen_shape.edge_a_x = prim_ch.edge_a_x;
                seen_shape.edge_b_x = prim_ch.edge_b_x;
                seen_shape.edge_c_x = prim_ch.edge_c_x;
                seen_shape.slope_a  = prim_ch.slope_a;
                seen_shape.slope_b  = prim_ch.slope_b;
                seen_shape.slope_c  = prim_ch.slope_c;
                seen_shape.top_y    = prim_ch.top_y;
                seen_shape.middle_y = prim_ch.middle_y;
                seen_shape.bottom_y = prim_ch.bottom_y;
                scoreboard.note_triangle(seen_shape);
            end
            if (bin_ch.valid && bin_ch.ready)
            begin
                seen_bin.visible      = bin_ch.visible;
                seen_bin.box_min_x    = bin_ch.box_min_x;
                seen_bin.box_max_x    = bin_ch.box_max_x;
                seen_bin.box_min_y    = bin_ch.box_min_y;
                seen_bin.box_max_y    = bin_ch.box_max_y;
                seen_bin.num_tiles    = bin_ch.num_tiles;
                seen_bin.batch_closed = bin_ch.batch_closed;
                seen_bin.batch_slot   = bin_ch.batch_slot;
                scoreboard.check_bin(seen_bin);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (prim_ch.valid && prim_ch.ready) || (bin_ch.valid && bin_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result receiver, with a long hold-off on request
    initial
    begin
        int unsigned served;
        int unsigned hold_left;
        served       = 0;
        hold_left    = 0;
        bin_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != holdoff_requests)
            begin
                served    = holdoff_requests;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                bin_ch.ready <= 1'b0;
            end
            else
                bin_ch.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    function automatic logic [31:0] px(longint p);
        longint v;
        v = p <<< FRAC_BITS;
        return v[31:0];
    endfunction

    function automatic triangle_t make_triangle(logic [31:0] ax, logic [31:0] bx,
                                                logic [31:0] cx, logic [31:0] sa,
                                                logic [31:0] sb, logic [31:0] sc,
                                                logic [15:0] ty, logic [15:0] my,
                                                logic [15:0] by);
        triangle_t t;
        t.edge_a_x = ax;
        t.edge_b_x = bx;
        t.edge_c_x = cx;
        t.slope_a  = sa;
        t.slope_b  = sb;
        t.slope_c  = sc;
        t.top_y    = ty;
        t.middle_y = my;
        t.bottom_y = by;
        return t;
    endfunction

    function automatic triangle_t random_triangle();
        triangle_t   t;
        logic [31:0] r;
        longint      y0, ym, y2, left, v, spans [3], starts [3], ends [3], slopes [3];
        int unsigned kind, x_reach, y_reach;
        bit          big;
        kind = $urandom_range(99, 0);
        if (kind < 15)
        begin
            t.edge_a_x = $urandom();
            t.edge_b_x = $urandom();
            t.edge_c_x = $urandom();
            t.slope_a  = $urandom();
            t.slope_b  = $urandom();
            t.slope_c  = $urandom();
            r = $urandom();
            t.top_y    = r[15:0];
            t.middle_y = r[31:16];
            r = $urandom();
            t.bottom_y = r[15:0];
            return t;
        end
        big     = ($urandom_range(9, 0) == 0);
        y_reach = big ? $urandom_range(16800, 0) : $urandom_range(384, 0);
        x_reach = big ? $urandom_range(2100, 0) : $urandom_range(48, 0);
        y0 = longint'($urandom_range(33600, 0)) - 1600;
        y2 = y0 + longint'(y_reach);
        if (y2 > 32767) y2 = 32767;
        ym = y0 + longint'($urandom_range(32'(y2 - y0), 0));
        left = longint'($urandom_range(4350, 0)) - 256;
        for (int i = 0; i < 3; i++)
        begin
            v = ((left + longint'($urandom_range(x_reach, 0))) <<< FRAC_BITS)
              + longint'($urandom_range(32'(FRAC_ROUND), 0));
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            starts[i] = v;
            v = ((left + longint'($urandom_range(x_reach, 0))) <<< FRAC_BITS)
              + longint'($urandom_range(32'(FRAC_ROUND), 0));
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            ends[i] = v;
        end
        spans[0] = y2 - y0;
        spans[1] = ym - y0;
        spans[2] = y2 - ym;
        for (int i = 0; i < 3; i++)
            slopes[i] = (spans[i] != 0) ? (ends[i] - starts[i]) / spans[i]
                                        : longint'($urandom());
        // broken ordering of the vertex rows
        if (kind < 22)
        begin
            v  = y0;
            y0 = y2;
            y2 = v;
        end
        t.edge_a_x = starts[0][31:0];
        t.edge_b_x = starts[1][31:0];
        t.edge_c_x = starts[2][31:0];
        t.slope_a  = slopes[0][31:0];
        t.slope_b  = slopes[1][31:0];
        t.slope_c  = slopes[2][31:0];
        t.top_y    = y0[15:0];
        t.middle_y = ym[15:0];
        t.bottom_y = y2[15:0];
        return t;
    endfunction

    task automatic send_triangle(input triangle_t shape);
        int unsigned gap;
        gap = 0;
        while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct)
            gap++;
        if (gap != 0)
        begin
            prim_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        prim_ch.valid    <= 1'b1;
        prim_ch.edge_a_x <= shape.edge_a_x;
        prim_ch.edge_b_x <= shape.edge_b_x;
        prim_ch.edge_c_x <= shape.edge_c_x;
        prim_ch.slope_a  <= shape.slope_a;
        prim_ch.slope_b  <= shape.slope_b;
        prim_ch.slope_c  <= shape.slope_c;
        prim_ch.top_y    <= shape.top_y;
        prim_ch.middle_y <= shape.middle_y;
        prim_ch.bottom_y <= shape.bottom_y;
        @(posedge clk);
        while (!prim_ch.ready) @(posedge clk);
    endtask

    task automatic settle();
        prim_ch.valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.expected_bins.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [11:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [10:0] sx, input logic [10:0] sy,
                             input logic [11:0] sw, input logic [11:0] sh,
                             input int src_pct, input int snk_pct,
                             input int unsigned items, input bit holdoff);
        settle();
        write_reg(CFG_SCISSOR_X, {1'b0, sx});
        write_reg(CFG_SCISSOR_Y, {1'b0, sy});
        write_reg(CFG_SCISSOR_WIDTH, sw);
        write_reg(CFG_SCISSOR_HEIGHT, sh);
        cfg_we             <= 1'b0;
        sender_idle_pct    = src_pct;
        receiver_stall_pct = snk_pct;
        if (holdoff)
            holdoff_requests++;
        repeat (items) send_triangle(random_triangle());
    endtask

    task automatic send_directed();
        triangle_t shapes[$];
        shapes.push_back('0);
        shapes.push_back(make_triangle(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                       16'h7fff, 16'h7fff, 16'h7fff));
        shapes.push_back(make_triangle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       16'h8000, 16'h8000, 16'h8000));
        shapes.push_back(make_triangle(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                                       32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                                       16'h5555, 16'haaaa, 16'h5555));
        shapes.push_back(make_triangle(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                                       32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                                       16'haaaa, 16'h5555, 16'haaaa));
        // full-screen boxes, the fourth one overflows the tile budget
        repeat (5)
            shapes.push_back(make_triangle(px(0), px(2048), px(2048), 32'd0, 32'd0, 32'd0,
                                           16'd0, 16'd8192, 16'd16384));
        // exactly one pixel
        shapes.push_back(make_triangle(px(5), px(6), px(5), 32'd0, 32'd0, 32'd0,
                                       16'd40, 16'd44, 16'd48));
        // sliver inside one pixel row
        shapes.push_back(make_triangle(px(5), px(9), px(7), 32'd0, 32'd0, 32'd0,
                                       16'd1, 16'd4, 16'd7));
        // crossing a tile corner
        shapes.push_back(make_triangle(px(15), px(17), px(16), 32'd0, 32'd0, 32'd0,
                                       16'd120, 16'd128, 16'd137));
        // negative coordinates, clipped at the scissor origin
        shapes.push_back(make_triangle(px(-100), px(50), px(-3), 32'd0, 32'd0, 32'd0,
                                       -16'sd800, 16'd0, 16'd400));
        // right of the scissor
        shapes.push_back(make_triangle(px(3000), px(3100), px(3050), 32'd0, 32'd0, 32'd0,
                                       16'd0, 16'd40, 16'd80));
        // end point product wraps
        shapes.push_back(make_triangle(px(10), px(12), px(11), 32'h7fff_ffff, 32'd3,
                                       32'hffff_fff0, 16'd0, 16'd8, 16'd16));
        // negative slopes
        shapes.push_back(make_triangle(px(100), px(100), px(60), -32'sd524288,
                                       -32'sd262144, 32'd65536, 16'd0, 16'd100, 16'd200));
        // middle row above the top row
        shapes.push_back(make_triangle(px(20), px(40), px(30), 32'd4096, -32'sd4096,
                                       32'd0, 16'd80, 16'd0, 16'd160));
        // top below bottom
        shapes.push_back(make_triangle(px(20), px(40), px(30), 32'd0, 32'd0, 32'd0,
                                       16'd160, 16'd80, 16'd0));
        // far corner of the coordinate range
        shapes.push_back(make_triangle(px(4095), px(4000), px(2040), 32'd0, 32'd0, 32'd0,
                                       16'd16000, 16'd30000, 16'h7fff));
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        foreach (shapes[i])
            send_triangle(shapes[i]);
    endtask

    initial
    begin
        logic [31:0] r0;
        logic [31:0] r1;
        scoreboard         = new();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        holdoff_requests   = 0;
        prim_ch.valid      = 1'b0;
        prim_ch.edge_a_x   = '0;
        prim_ch.edge_b_x   = '0;
        prim_ch.edge_c_x   = '0;
        prim_ch.slope_a    = '0;
        prim_ch.slope_b    = '0;
        prim_ch.slope_c    = '0;
        prim_ch.top_y      = '0;
        prim_ch.middle_y   = '0;
        prim_ch.bottom_y   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_directed();

        run_phase(11'd0, 11'd0, 12'd2048, 12'd2048, 0, 0, 160, 1'b0);
        run_phase(11'd2047, 11'd2047, 12'd2048, 12'd2048, 51, 0, 160, 1'b0);
        run_phase(11'd0, 11'd0, 12'd0, 12'd0, 0, 51, 60, 1'b0);
        run_phase(11'd100, 11'd37, 12'd4095, 12'd4095, 26, 26, 160, 1'b0);
        run_phase(11'd0, 11'd0, 12'd1, 12'd1, 0, 51, 100, 1'b0);
        run_phase(11'd2047, 11'd0, 12'd1, 12'd2048, 26, 26, 100, 1'b0);
        run_phase(11'd512, 11'd300, 12'd1024, 12'd700, 51, 0, 160, 1'b0);
        r0 = $urandom();
        r1 = $urandom();
        run_phase(r0[10:0], r0[21:11], r1[11:0], r1[23:12], 0, 0, 160, 1'b0);
        r0 = $urandom();
        r1 = $urandom();
        run_phase(r0[10:0], r0[21:11], {1'b0, r1[10:0]}, {1'b0, r1[22:12]}, 0, 51, 160, 1'b0);
        r0 = $urandom();
        r1 = $urandom();
        run_phase(r0[10:0], r0[21:11], r1[11:0], r1[23:12], 26, 26, 160, 1'b0);

        // receiver holds off while words keep coming
        run_phase(11'd0, 11'd0, 12'd2048, 12'd2048, 0, 0, 60, 1'b1);

        // a run of empty triangles
        run_phase(11'd0, 11'd0, 12'd2048, 12'd2048, 0, 0, 0, 1'b0);
        repeat (EMPTY_RUN) send_triangle('0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (scoreboard.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/tbts_pkg.sv
design/tbts_if.sv
design/tbts_front.sv
design/tbts_queue.sv
design/tbts_back.sv
design/triangle_bbox_tile_binning_setup_top.sv
tb/tb_triangle_bbox_tile_binning_setup_top.sv
